### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_screen_ram, tcw_cursor and text_console_writer; no dependencies.
`default_nettype none

package tcw_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 12;  // linear cell address, enough for 127 x 31 cells
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int DATA_W = 16;
  localparam int CHAR_W = 8;
  localparam int LOC_W  = 11;
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 11;
  localparam int CFG_W  = 8;

  // Default screen geometry.
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ATTRIBUTE = 1'b0;
  localparam logic REG_WRAP_HOME = 1'b1;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

  localparam logic [DATA_W-1:0] RESET_CELL     = 16'h0720;
  localparam logic [CFG_W-1:0]  RESET_ATTRIBUTE = 8'h07;

  // Cursor update commands.
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_BACK,
    CUR_RETURN,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_HOME,
    CUR_BOTTOM
  } cur_cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_BOTTOM,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_FILL,
    S_READ,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/text_console_writer.sv
// Text console writer: top level with the sequencer, configuration and result register.
// Depends on tcw_pkg, tcw_screen_ram and tcw_cursor.
`default_nettype none

// A text-mode console holding a COLS x ROWS screen of 16-bit cells (attribute
// in the high byte, character in the low byte) in a single-port-write,
// registered-read memory, plus a cursor. Each input beat is one operation:
// print a character, read a cell, or clear the screen; each produces exactly
// one output beat carrying the cell read (zero for other operations) and the
// linear cursor location after the operation. One operation is handled at a
// time and in_ready is low while it runs. Clearing the screen writes every
// cell, one memory write per cycle. A character that pushes the cursor past
// the bottom row in scroll mode also moves the screen up one row: every moved
// cell is read and then written through the one memory, followed by one write
// per cell of the blank bottom row. After reset the block writes the reset
// pattern into every cell of the memory before it raises in_ready;
// configuration writes are taken during that pass. Configuration registers
// (attribute, wrap_home) should be written only while the block is idle. A
// finished result sits in the output register until it is taken, and a new
// beat is accepted meanwhile.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [IDX_W-1:0]  cell_index,
  // Output channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] cell_data,
  output logic      [LOC_W-1:0]  cursor_location
);

  localparam int CELLS = COLS * ROWS;
  localparam logic [ADDR_W-1:0] CELLS_A      = ADDR_W'(CELLS);
  localparam logic [ADDR_W-1:0] COLS_A       = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] SCROLL_LAST  = ADDR_W'(CELLS - COLS - 1);
  localparam logic [ROW_W-1:0]  ROWS_R       = ROW_W'(ROWS);
  localparam logic              HAS_SCROLL   = (CELLS > COLS);

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [CFG_W-1:0] attribute;
  logic             wrap_home;

  // Captured operation.
  logic [FUNC_W-1:0] func_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;

  // Sweep counter, its last address and the value written by a fill sweep.
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_next;
  logic [ADDR_W-1:0] last;
  logic [ADDR_W-1:0] last_next;
  logic [DATA_W-1:0] fill;
  logic [DATA_W-1:0] fill_next;

  // Cell value returned by the operation.
  logic [DATA_W-1:0] data;
  logic [DATA_W-1:0] data_next;

  // Memory and cursor control.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  cur_cmd_t          cur_cmd;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] cur_pos_next;
  logic [ROW_W-1:0]  cur_row;

  logic              in_beat;
  logic              out_free;
  logic              idx_ok;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_ok   = (ADDR_W'(idx_q) < CELLS_A);

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cur_cmd),
    .pos      (cur_pos),
    .pos_next (cur_pos_next),
    .row      (cur_row)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (addr == last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q)
          FUNC_PRINT: begin
            if (char_q == CH_BACKSPACE || char_q == CH_RETURN) begin
              state_next = S_DONE;
            end else begin
              state_next = S_BOTTOM;
            end
          end
          FUNC_READ: begin
            state_next = idx_ok ? S_READ : S_DONE;
          end
          FUNC_CLEAR: begin
            state_next = S_FILL;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_BOTTOM: begin
        if (cur_row != ROWS_R || wrap_home) begin
          state_next = S_DONE;
        end else if (HAS_SCROLL) begin
          state_next = S_SCROLL_RD;
        end else begin
          state_next = S_FILL;
        end
      end
      S_SCROLL_RD: begin
        state_next = S_SCROLL_WR;
      end
      S_SCROLL_WR: begin
        state_next = (addr == SCROLL_LAST) ? S_FILL : S_SCROLL_RD;
      end
      S_FILL: begin
        if (addr == last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control for each state: memory port, cursor command and sweep.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = fill;
    ram_raddr = ADDR_W'(idx_q);
    cur_cmd   = CUR_HOLD;
    addr_next = addr;
    last_next = last;
    fill_next = fill;
    data_next = data;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        addr_next = addr + ADDR_W'(1);
      end
      S_IDLE: begin
        data_next = '0;
      end
      S_EXEC: begin
        case (func_q)
          FUNC_PRINT: begin
            if (char_q == CH_BACKSPACE) begin
              // The cell at the new cursor position is blanked.
              cur_cmd   = CUR_BACK;
              ram_we    = 1'b1;
              ram_waddr = cur_pos_next;
              ram_wdata = {attribute, CH_NUL};
            end else if (char_q == CH_RETURN) begin
              cur_cmd = CUR_RETURN;
            end else if (char_q == CH_NEWLINE) begin
              cur_cmd = CUR_NEWLINE;
            end else begin
              cur_cmd   = CUR_ADVANCE;
              ram_we    = 1'b1;
              ram_waddr = cur_pos;
              ram_wdata = {attribute, char_q};
            end
          end
          FUNC_CLEAR: begin
            addr_next = '0;
            last_next = LAST_CELL;
            fill_next = {attribute, CH_SPACE};
          end
          default: begin
            cur_cmd = CUR_HOLD;
          end
        endcase
      end
      S_BOTTOM: begin
        if (cur_row == ROWS_R) begin
          if (wrap_home) begin
            cur_cmd = CUR_HOME;
          end else begin
            cur_cmd   = CUR_BOTTOM;
            addr_next = HAS_SCROLL ? '0 : BOTTOM_START;
            last_next = LAST_CELL;
            fill_next = {attribute, CH_NUL};
          end
        end
      end
      S_SCROLL_RD: begin
        ram_raddr = addr + COLS_A;
      end
      S_SCROLL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        addr_next = addr + ADDR_W'(1);
      end
      S_FILL: begin
        ram_we    = 1'b1;
        addr_next = addr + ADDR_W'(1);
      end
      S_READ: begin
        data_next = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      attribute <= RESET_ATTRIBUTE;
      wrap_home <= 1'b0;
      addr      <= '0;
      last      <= LAST_CELL;
      fill      <= RESET_CELL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
      last  <= last_next;
      fill  <= fill_next;
      if (cfg_we) begin
        if (cfg_index == REG_ATTRIBUTE) begin
          attribute <= cfg_data;
        end else begin
          wrap_home <= cfg_data[0];
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    data <= data_next;
    if (in_beat) begin
      func_q <= func;
      char_q <= char_code;
      idx_q  <= cell_index;
    end
    if (state == S_DONE && out_free) begin
      cell_data       <= data;
      cursor_location <= cur_pos[LOC_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/tcw_screen_ram.sv
// Screen cell memory: one write port and one registered read port.
// Depends on tcw_pkg for the address and data widths.
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_COLS * DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

endmodule

`default_nettype wire

### rtl/tcw_cursor.sv
// Cursor column, row and linear position; relative moves of the position share one adder.
// Depends on tcw_pkg for widths and the cursor command type.
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cur_cmd_t          cmd,
  output logic      [ADDR_W-1:0] pos,
  output logic      [ADDR_W-1:0] pos_next,
  output logic      [ROW_W-1:0]  row
);

  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] ONE_A      = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] BOTTOM_POS = ADDR_W'((ROWS - 1) * COLS);

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] delta;
  logic [ADDR_W-1:0] sum;
  logic [ADDR_W-1:0] col_ext;

  assign col_ext = ADDR_W'(col);
  // The shared adder: every relative move, but a backspace from the top-left cell, is pos plus a chosen step.
  assign sum = pos + delta;

  always_comb begin
    col_next = col;
    row_next = row;
    delta    = '0;
    pos_next = pos;
    case (cmd)
      CUR_BACK: begin
        delta = '1;  // minus one
        if (col == '0) begin
          col_next = LAST_COL;
          if (row != '0) begin
            row_next = row - ROW_W'(1);
            pos_next = sum;
          end else begin
            pos_next = ADDR_W'(LAST_COL);
          end
        end else begin
          col_next = col - COL_W'(1);
          pos_next = sum;
        end
      end
      CUR_RETURN: begin
        delta    = ~col_ext + ONE_A;
        col_next = '0;
        pos_next = sum;
      end
      CUR_NEWLINE: begin
        delta    = COLS_A - col_ext;
        col_next = '0;
        row_next = row + ROW_W'(1);
        pos_next = sum;
      end
      CUR_ADVANCE: begin
        delta = ONE_A;
        if (col == LAST_COL) begin
          col_next = '0;
          row_next = row + ROW_W'(1);
        end else begin
          col_next = col + COL_W'(1);
        end
        pos_next = sum;
      end
      CUR_HOME: begin
        col_next = '0;
        row_next = '0;
        pos_next = '0;
      end
      CUR_BOTTOM: begin
        col_next = '0;
        row_next = LAST_ROW;
        pos_next = BOTTOM_POS;
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pos <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

### tb/console_checker.sv
// Result checker for the text console writer: keeps its own copy of the screen and
// cursor, predicts one result per accepted input beat and compares output beats.
// Depends on tcw_pkg for field widths, operation codes and character codes.

module console_checker
  import tcw_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [IDX_W-1:0]  cell_index,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [DATA_W-1:0] cell_data,
  input  wire logic [LOC_W-1:0]  cursor_location,
  output int                     pending,
  output int                     mismatches,
  output int                     scrolls,
  output int                     homes
);

  localparam int CELLS = COLS * ROWS;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LOC_W-1:0]  loc;
  } console_result_t;

  logic [DATA_W-1:0] screen [CELLS];
  int                col;
  int                row;
  logic [CFG_W-1:0]  attr;
  logic              wrap;
  console_result_t   awaited [$];
  int                results_seen;

  function automatic logic [DATA_W-1:0] cell_of(input logic [CHAR_W-1:0] ch);
    return {attr, ch};
  endfunction

  task automatic put_cell(input int c, input int r, input logic [CHAR_W-1:0] ch);
    int pos;
    pos = r * COLS + c;
    if (pos < CELLS) begin
      screen[pos] = cell_of(ch);
    end
  endtask

  // Cursor has run off the bottom row: scroll up one row or go home.
  task automatic past_bottom();
    if (row < ROWS) begin
      return;
    end
    if (wrap) begin
      col = 0;
      row = 0;
      homes++;
    end else begin
      for (int i = 0; i + COLS < CELLS; i++) begin
        screen[i] = screen[i + COLS];
      end
      for (int i = 0; i < COLS; i++) begin
        put_cell(i, ROWS - 1, CH_NUL);
      end
      row = ROWS - 1;
      scrolls++;
    end
  endtask

  task automatic print_char(input logic [CHAR_W-1:0] ch);
    if (ch == CH_BACKSPACE) begin
      if (col == 0) begin
        col = COLS - 1;
        if (row > 0) begin
          row--;
        end
      end else begin
        col--;
      end
      put_cell(col, row, CH_NUL);
    end else if (ch == CH_RETURN) begin
      col = 0;
    end else if (ch == CH_NEWLINE) begin
      col = 0;
      row++;
      past_bottom();
    end else begin
      put_cell(col, row, ch);
      col++;
      if (col >= COLS) begin
        col = 0;
        row++;
      end
      past_bottom();
    end
  endtask

  task automatic predict_op(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx, output console_result_t res);
    res.data = '0;
    case (f)
      FUNC_PRINT: begin
        print_char(ch);
      end
      FUNC_READ: begin
        if (int'(idx) < CELLS) begin
          res.data = screen[idx];
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen[i] = cell_of(CH_SPACE);
        end
      end
      default: begin
      end
    endcase
    res.loc = LOC_W'(row * COLS + col);
  endtask

  task automatic reset_console();
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = RESET_CELL;
    end
    col  = 0;
    row  = 0;
    attr = RESET_ATTRIBUTE;
    wrap = 1'b0;
    awaited.delete();
  endtask

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] wanted);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch on result beat %0d: %s is %0h, expected %0h",
               results_seen, what, seen, wanted);
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      reset_console();
      mismatches   = 0;
      scrolls      = 0;
      homes        = 0;
      results_seen = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ATTRIBUTE) begin
          attr = cfg_data;
        end else begin
          wrap = cfg_data[0];
        end
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report("result with nothing awaited, location", 32'(cursor_location), 32'h0);
        end else begin
          want = awaited.pop_front();
          if (cell_data !== want.data) begin
            report("cell_data", 32'(cell_data), 32'(want.data));
          end
          if (cursor_location !== want.loc) begin
            report("cursor_location", 32'(cursor_location), 32'(want.loc));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        predict_op(func, char_code, cell_index, want);
        awaited.push_back(want);
      end
      pending <= awaited.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the text console writer testbench: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, the text_console_writer RTL and console_checker.

module testbench;
  import tcw_pkg::*;

  localparam int CELLS = DEF_COLS * DEF_ROWS;

  // The fourth operation code has no meaning; the block must leave all state alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [CFG_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic [FUNC_W-1:0] func       = '0;
  logic [CHAR_W-1:0] char_code  = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              out_ready  = 1'b1;
  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] cell_data;
  logic [LOC_W-1:0]  cursor_location;

  int pending;
  int mismatches;
  int scrolls;
  int homes;

  // When set, both the sender and the receiver insert random idle bursts.
  bit idling = 1'b1;

  int n_print;
  int n_read;
  int n_clear;
  int n_unused;

  always #1 clk = ~clk;

  text_console_writer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_data       (cell_data),
    .cursor_location (cursor_location)
  );

  console_checker watch (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_data       (cell_data),
    .cursor_location (cursor_location),
    .pending         (pending),
    .mismatches      (mismatches),
    .scrolls         (scrolls),
    .homes           (homes)
  );

  // Receiver: out_ready drops for bursts of random length now and then. Each pass of
  // the loop waits on a clock edge first, so out_ready is never assigned twice in a step.
  always begin
    @(posedge clk);
    if (idling && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  // Safety net. The slowest expected run is dominated by scrolls and clears, which
  // each walk the screen memory.
  initial begin
    #8000000;
    $display("run timed out with %0d results outstanding", pending);
    $display("testbench: FAIL");
    $finish;
  end

  // Offers one input beat and returns at the edge where it is accepted. Valid is only
  // lowered when an idle gap is due, so back-to-back beats keep it high throughout.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                         input logic [IDX_W-1:0] idx);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    case (f)
      FUNC_PRINT: n_print++;
      FUNC_READ:  n_read++;
      FUNC_CLEAR: n_clear++;
      default:    n_unused++;
    endcase
  endtask

  task automatic print_ch(input logic [CHAR_W-1:0] ch);
    send_op(FUNC_PRINT, ch, IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int idx);
    send_op(FUNC_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
  endtask

  // Holds the sender back until every awaited result has arrived. The first edge lets
  // the checker count a beat accepted at the edge this is called on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the write enable stays high between.
  task automatic set_console(input logic [CFG_W-1:0] attr, input logic [CFG_W-1:0] wrap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ATTRIBUTE;
    cfg_data  <= attr;
    @(posedge clk);
    cfg_index <= REG_WRAP_HOME;
    cfg_data  <= wrap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random beat. Reads mostly land on the screen, with one in sixteen past its end.
  // nl_pct sets the share of newlines in percent; it is kept low in scroll mode, since
  // every scroll walks the whole screen memory.
  task automatic send_random(input int nl_pct);
    int r;
    r = $urandom_range(0, 999);
    if (r < 10) begin
      send_op(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
    end else if (r < 30) begin
      send_op(FUNC_UNUSED, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
    end else if (r < 280) begin
      if ($urandom_range(0, 15) == 0) begin
        read_cell($urandom_range(CELLS, 2047));
      end else begin
        read_cell($urandom_range(0, CELLS - 1));
      end
    end else if (r < 280 + 10 * nl_pct) begin
      print_ch(CH_NEWLINE);
    end else if (r < 340 + 10 * nl_pct) begin
      print_ch(CH_BACKSPACE);
    end else if (r < 380 + 10 * nl_pct) begin
      print_ch(CH_RETURN);
    end else begin
      print_ch(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  // A phase starts from an idle block, sets both registers, and drains once halfway so
  // that the sender is seen waiting for every result at least once per phase.
  task automatic run_phase(input logic [CFG_W-1:0] attr, input logic [CFG_W-1:0] wrap,
                           input bit idle, input int nl_pct, input int beats);
    settle();
    set_console(attr, wrap);
    idling = idle;
    for (int i = 0; i < beats; i++) begin
      if (i == beats / 2) begin
        settle();
      end
      send_random(nl_pct);
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Registers can be taken while the block is still painting the reset pattern.
    set_console(8'h00, 8'h00);

    // Directed part. Reads of the reset screen at both ends, just past the end and at the last index.
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
    // Character extremes, then a backspace and a read of the cell it blanked.
    print_ch(8'hFF);
    print_ch(8'h00);
    print_ch(8'h41);
    print_ch(CH_BACKSPACE);
    read_cell(2);
    // Carriage return homes the column; a backspace at column zero on the top row
    // goes to the last column and stays on row zero.
    print_ch(CH_RETURN);
    print_ch(CH_BACKSPACE);
    // A printable in the last column wraps onto the next row.
    print_ch(8'h7E);
    send_op(FUNC_UNUSED, 8'hFF, 11'h7FF);
    send_op(FUNC_CLEAR, 8'h00, 11'h000);
    // Walk down with newlines until the screen scrolls once.
    repeat (DEF_ROWS - 1) print_ch(CH_NEWLINE);
    read_cell(CELLS - 1);
    read_cell(0);
    // Same overflow in wrap mode: the cursor goes home and nothing is cleared.
    settle();
    set_console(8'hFF, 8'hFF);
    print_ch(CH_NEWLINE);
    print_ch(CH_BACKSPACE);
    read_cell(DEF_COLS - 1);

    // Random part. Scroll phases keep newlines rare; wrap phases lean on them so the
    // cursor reaches the bottom often. The third phase has no idling at all, and the
    // last one neither, to finish at full rate.
    run_phase(8'h1E, 8'h00, 1'b1, 4, 400);
    run_phase(8'hFF, 8'h01, 1'b1, 15, 400);
    run_phase(CFG_W'($urandom_range(1, 254)), 8'hFE, 1'b0, 4, 250);
    run_phase(8'h00, 8'hFF, 1'b1, 15, 400);
    run_phase(CFG_W'($urandom_range(1, 254)), CFG_W'($urandom_range(0, 127) * 2), 1'b1, 6, 250);
    run_phase(CFG_W'($urandom_range(0, 255)), 8'h01, 1'b0, 15, 150);

    // Wait for the last results; the longest single operation is a scroll.
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d prints, %0d reads, %0d clears and %0d unused-code beats",
             n_print, n_read, n_clear, n_unused);
    $display("bottom row overflowed %0d times with scrolling and %0d times going home; %0d results missing, %0d mismatches",
             scrolls, homes, pending, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_writer.sv
tb/console_checker.sv
tb/testbench.sv
